[rtl/core/rvc_pkg.sv]
// Shared constants and types for the repeated value counter.
`default_nettype none

package rvc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int COUNT_MAX   = 31;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

[rtl/core/repeated_value_counter_core.sv]
// Top level: counts distinct values that repeat within a vector.
//
// Input stream (s_axis): one signed 32-bit vector element per request in
// tdata, tlast on the final element of the vector. Output stream (m_axis):
// one request per vector, sent after the element with tlast, carrying the
// number of distinct values seen two or more times and an overflow flag.
//
// The distinct values live in a single-port-read table memory with a
// registered read. Each element walks the table one entry per cycle,
// over the N distinct values stored so far (at most TABLE_DEPTH, which
// is 16 by default). The walk stops early on a match. One element is in
// work at a time.
//
// Reset (synchronous, active low) empties the table, clears the repeat
// marks, the tally and the overflow flag, and drops the output request.
// The result sits in an output register: new elements are taken while it
// waits. Only an element with tlast stalls, at its end, until the previous
// result has been taken. After each result the block is clear again.
`default_nettype none

module repeated_value_counter_core
    import rvc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [VALUE_W-1:0]     i_s_axis_tdata,   // [31:0] element_value
    input  wire logic                   i_s_axis_tlast,   // is_last
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata    // [4:0] repeated_count, [5] overflowed
);

    logic [VALUE_W-1:0]     r_table [TABLE_DEPTH];
    logic [VALUE_W-1:0]     r_rd_data;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;

    t_state                 r_state,     n_state;
    logic [TABLE_DEPTH-1:0] r_marks,     n_marks;
    logic [USED_W-1:0]      r_used,      n_used;
    logic [USED_W-1:0]      r_tally,     n_tally;
    logic                   r_ovf,       n_ovf;
    logic [VALUE_W-1:0]     r_value,     n_value;
    logic                   r_last,      n_last;
    logic [USED_W-1:0]      r_issue_idx, n_issue_idx;
    logic                   r_cmp_vld,   n_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx,   n_cmp_idx;
    logic                   r_found,     n_found;
    logic [IDX_W-1:0]       r_hit_idx,   n_hit_idx;
    logic                   r_out_vld,   n_out_vld;
    logic [COUNT_W-1:0]     r_out_cnt,   n_out_cnt;
    logic                   r_out_ovf,   n_out_ovf;

    logic                   cmp_hit;
    logic                   cmp_end;
    logic                   issue;
    logic                   table_full;
    logic                   new_repeat;
    logic [USED_W-1:0]      fin_tally;
    logic                   fin_ovf;
    logic                   out_free;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= r_value;
        end
        r_rd_data <= r_table[rd_addr];
    end

    assign rd_addr    = r_issue_idx[IDX_W-1:0];
    assign wr_addr    = r_used[IDX_W-1:0];
    assign table_full = (r_used == USED_W'(TABLE_DEPTH));
    assign cmp_hit    = r_cmp_vld && (r_rd_data == r_value);
    assign cmp_end    = r_cmp_vld && ((USED_W'(r_cmp_idx) + USED_W'(1)) == r_used);
    assign issue      = (r_issue_idx < r_used) && !cmp_hit;
    assign new_repeat = r_found && !r_marks[r_hit_idx];
    assign fin_tally  = r_tally + USED_W'(new_repeat);
    assign fin_ovf    = r_ovf || (!r_found && table_full);
    assign out_free   = !r_out_vld || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_marks     = r_marks;
        n_used      = r_used;
        n_tally     = r_tally;
        n_ovf       = r_ovf;
        n_value     = r_value;
        n_last      = r_last;
        n_issue_idx = r_issue_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_out_vld   = r_out_vld && !i_m_axis_tready;
        n_out_cnt   = r_out_cnt;
        n_out_ovf   = r_out_ovf;
        wr_en       = 1'b0;
        o_s_axis_tready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_value     = i_s_axis_tdata;
                    n_last      = i_s_axis_tlast;
                    n_issue_idx = '0;
                    n_found     = 1'b0;
                    n_state     = (r_used == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_hit) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_state   = ST_FINISH;
                end else if (cmp_end) begin
                    n_state = ST_FINISH;
                end else if (issue) begin
                    n_cmp_vld   = 1'b1;
                    n_cmp_idx   = r_issue_idx[IDX_W-1:0];
                    n_issue_idx = r_issue_idx + USED_W'(1);
                end
            end
            ST_FINISH: begin
                if (!r_last || out_free) begin
                    n_state = ST_IDLE;
                    if (r_last) begin
                        n_out_vld = 1'b1;
                        n_out_cnt = (32'(fin_tally) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                                : COUNT_W'(fin_tally);
                        n_out_ovf = fin_ovf;
                        n_marks   = '0;
                        n_used    = '0;
                        n_tally   = '0;
                        n_ovf     = 1'b0;
                    end else begin
                        n_tally = fin_tally;
                        n_ovf   = fin_ovf;
                        if (new_repeat) begin
                            n_marks[r_hit_idx] = 1'b1;
                        end
                        if (!r_found && !table_full) begin
                            wr_en            = 1'b1;
                            n_marks[wr_addr] = 1'b0;
                            n_used           = r_used + USED_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_marks   <= '0;
            r_used    <= '0;
            r_tally   <= '0;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_marks   <= n_marks;
            r_used    <= n_used;
            r_tally   <= n_tally;
            r_ovf     <= n_ovf;
            r_cmp_vld <= n_cmp_vld;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_last      <= n_last;
        r_issue_idx <= n_issue_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_hit_idx   <= n_hit_idx;
        r_out_cnt   <= n_out_cnt;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - COUNT_W - 1)'(0), r_out_ovf, r_out_cnt};

endmodule

`default_nettype wire

[rtl/core/rvc_checker.sv]
// Port-level checks for the repeated value counter, bound to the top level.
`default_nettype none

module rvc_checker
    import rvc_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output request present after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[COUNT_W-1:0]) <= TABLE_DEPTH)
                            && (o_m_axis_tdata[OUT_TDATA_W-1:COUNT_W+1] == '0))
        else $error("result count beyond table depth or padding set");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second element taken while one is in work");

endmodule

bind repeated_value_counter_core rvc_checker u_rvc_checker (.*);

`default_nettype wire
